// ===== hdl/ors_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Overwriting ring stack package
// Opcodes, field widths and the shift command passed from control to the cells.
// ----------------------------------------------------------------------------
package ors_pkg;

  localparam int OPCODE_WIDTH = 2;

  localparam logic [OPCODE_WIDTH-1:0] OP_PUSH  = 2'd0;
  localparam logic [OPCODE_WIDTH-1:0] OP_POP   = 2'd1;
  localparam logic [OPCODE_WIDTH-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/ors_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Overwriting ring stack channels
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface ors_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                             valid;
  logic                             ready;
  logic [ors_pkg::OPCODE_WIDTH-1:0] opcode;
  logic [VALUE_WIDTH-1:0]           push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface ors_out_if #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 9
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] popped_value;
  logic                   popped_valid;
  logic [VALUE_WIDTH-1:0] evicted_value;
  logic                   evicted;
  logic [COUNT_WIDTH-1:0] fill_count;

  modport source (output valid, output popped_value, output popped_valid,
                  output evicted_value, output evicted, output fill_count,
                  input ready);
  modport sink   (input valid, input popped_value, input popped_valid,
                  input evicted_value, input evicted, input fill_count,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/overwriting_ring_stack_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Overwriting ring stack
// Bounded LIFO of 2^DEPTH_BITS entries that drops its oldest entry when full.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one operation per beat: push (stores push_value), pop, or
//   clear; any other opcode leaves the stack alone. out_ch returns exactly one
//   result beat per operation beat, in order: the popped value, the value
//   evicted by a push into a full stack, and the fill count afterwards.
//   The entries live in a chain of cells with the newest at the front; a push
//   shifts the whole chain one cell back and a pop one cell forward.
//   The result beat is registered and valid the cycle after the operation beat.
//   Throughput: one operation per cycle, set by the single result register;
//   in_ch.ready drops only while a result waits and out_ch.ready is low.
//   Reset empties the stack (fill count zero) and drops any pending result;
//   cell contents are not cleared and are never read before being written.
//   A stalled receiver holds the result steady and stalls the sender.
// ----------------------------------------------------------------------------
module overwriting_ring_stack_top #(
  parameter int DEPTH_BITS  = 8,
  parameter int VALUE_WIDTH = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  ors_in_if.sink    in_ch,
  ors_out_if.source out_ch
);

  localparam int NUM_CELLS   = 1 << DEPTH_BITS;
  localparam int COUNT_WIDTH = DEPTH_BITS + 1;
  localparam logic [COUNT_WIDTH-1:0] CAPACITY = COUNT_WIDTH'(1) << DEPTH_BITS;

  ors_pkg::shift_cmd_t    cmd;
  logic [VALUE_WIDTH-1:0] cell_q [NUM_CELLS];

  ors_ctrl #(
    .DEPTH_BITS  (DEPTH_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .top_value    (cell_q[0]),
    .bottom_value (cell_q[NUM_CELLS-1]),
    .cmd          (cmd)
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] newer;
    logic [VALUE_WIDTH-1:0] older;

    if (i == 0) begin : g_front
      assign newer = in_ch.push_value;
    end else begin : g_inner_newer
      assign newer = cell_q[i-1];
    end

    if (i == NUM_CELLS - 1) begin : g_back
      assign older = '0;
    end else begin : g_inner_older
      assign older = cell_q[i+1];
    end

    ors_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .from_newer (newer),
      .from_older (older),
      .q          (cell_q[i])
    );
  end

`ifndef SYNTHESIS
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop))
    else $error("push and pop shift issued together");

  a_pop_reports: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> (out_ch.valid && out_ch.popped_valid && !out_ch.evicted))
    else $error("pop shift without a popped result");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.evicted) |-> (out_ch.fill_count == CAPACITY))
    else $error("eviction reported while stack not full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.fill_count <= CAPACITY))
    else $error("fill count beyond capacity");
`endif

endmodule
`default_nettype wire

// ===== hdl/ors_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack cell
// One entry of the shift stack: takes the newer neighbor on push, the older
// neighbor on pop, and holds otherwise.
// ----------------------------------------------------------------------------
module ors_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire ors_pkg::shift_cmd_t    cmd,
  input  wire logic [VALUE_WIDTH-1:0] from_newer,
  input  wire logic [VALUE_WIDTH-1:0] from_older,
  output logic      [VALUE_WIDTH-1:0] q
);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      q <= from_newer;
    end else if (cmd.pop) begin
      q <= from_older;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ors_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack control
// Fill count, handshake and result register; drives the shift command.
// ----------------------------------------------------------------------------
module ors_ctrl #(
  parameter int DEPTH_BITS  = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  ors_in_if.sink                      in_ch,
  ors_out_if.source                   out_ch,
  input  wire logic [VALUE_WIDTH-1:0] top_value,
  input  wire logic [VALUE_WIDTH-1:0] bottom_value,
  output ors_pkg::shift_cmd_t         cmd
);

  localparam int COUNT_WIDTH = DEPTH_BITS + 1;
  localparam logic [COUNT_WIDTH-1:0] CAPACITY = COUNT_WIDTH'(1) << DEPTH_BITS;

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   out_valid;
  logic                   accept;
  logic                   full;
  logic                   empty;
  logic                   clear;

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign full         = (count == CAPACITY);
  assign empty        = (count == '0);
  assign cmd.push     = accept && (in_ch.opcode == ors_pkg::OP_PUSH);
  assign cmd.pop      = accept && (in_ch.opcode == ors_pkg::OP_POP) && !empty;
  assign clear        = accept && (in_ch.opcode == ors_pkg::OP_CLEAR);
  assign out_ch.valid = out_valid;

  always_comb begin
    count_next = count;
    if (clear) begin
      count_next = '0;
    end else if (cmd.push && !full) begin
      count_next = count + COUNT_WIDTH'(1);
    end else if (cmd.pop) begin
      count_next = count - COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A push into a full stack loses the oldest cell off the end of the chain.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.popped_valid  <= cmd.pop;
      out_ch.popped_value  <= cmd.pop ? top_value : '0;
      out_ch.evicted       <= cmd.push && full;
      out_ch.evicted_value <= (cmd.push && full) ? bottom_value : '0;
      out_ch.fill_count    <= count_next;
    end
  end

endmodule
`default_nettype wire

// ===== sim/overwriting_ring_stack_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overwriting ring stack testbench
// Sends push, pop, clear and unused-opcode beats with random gaps on the
// operation channel and random stalls on the result channel. A scoreboard keeps
// its own copy of the stack and checks each result beat in order.
// ----------------------------------------------------------------------------
module overwriting_ring_stack_top_test;

  localparam int DEPTH_BITS   = 8;
  localparam int VALUE_WIDTH  = 32;
  localparam int COUNT_WIDTH  = DEPTH_BITS + 1;
  localparam int CAPACITY     = 1 << DEPTH_BITS;
  localparam int TARGET_OPS   = 1850;
  localparam int QUIET_OPS    = 1650;
  localparam int LIMIT_CYCLES = 400000;

  // The package names only the three real operations; code three does nothing.
  localparam logic [ors_pkg::OPCODE_WIDTH-1:0] OP_UNUSED = 2'd3;

  typedef enum int {SEG_FILL, SEG_GROW, SEG_DRAIN, SEG_MIXED} seg_kind_t;

  class stack_scoreboard;
    typedef struct packed {
      logic [VALUE_WIDTH-1:0] popped_value;
      logic                   popped_valid;
      logic [VALUE_WIDTH-1:0] evicted_value;
      logic                   evicted;
      logic [COUNT_WIDTH-1:0] fill_count;
    } stack_result_t;

    bit [VALUE_WIDTH-1:0] slots[CAPACITY];
    bit [DEPTH_BITS-1:0]  oldest_idx;
    bit [DEPTH_BITS-1:0]  next_free_idx;
    bit [COUNT_WIDTH-1:0] depth_used;
    stack_result_t        results_due[$];
    int                   mismatches;

    function void note_op(logic [ors_pkg::OPCODE_WIDTH-1:0] op,
                          logic [VALUE_WIDTH-1:0] value);
      stack_result_t want;
      want = '0;
      case (op)
        ors_pkg::OP_PUSH: begin
          if (depth_used == CAPACITY) begin
            want.evicted_value = slots[oldest_idx];
            want.evicted = 1'b1;
            oldest_idx++;
            depth_used--;
          end
          slots[next_free_idx] = value;
          next_free_idx++;
          depth_used++;
        end
        ors_pkg::OP_POP: begin
          if (depth_used != 0) begin
            next_free_idx--;
            want.popped_value = slots[next_free_idx];
            want.popped_valid = 1'b1;
            depth_used--;
          end
        end
        ors_pkg::OP_CLEAR: begin
          oldest_idx = '0;
          next_free_idx = '0;
          depth_used = '0;
        end
        default: ;
      endcase
      want.fill_count = depth_used;
      results_due.push_back(want);
    endfunction

    function void check_result(stack_result_t got);
      stack_result_t want;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing outstanding: %p", $realtime, got);
        return;
      end
      want = results_due.pop_front();
      if (got.popped_value !== want.popped_value || got.popped_valid !== want.popped_valid ||
          got.evicted_value !== want.evicted_value || got.evicted !== want.evicted ||
          got.fill_count !== want.fill_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch, expected %p, actual %p", $realtime, want, got);
      end
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  ors_in_if  #(.VALUE_WIDTH(VALUE_WIDTH)) op_ch ();
  ors_out_if #(.VALUE_WIDTH(VALUE_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) res_ch ();

  overwriting_ring_stack_top #(
    .DEPTH_BITS (DEPTH_BITS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (op_ch),
    .out_ch(res_ch)
  );

  stack_scoreboard sb = new();

  bit in_gaps_on;
  bit out_stalls_on;
  int ops_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // Both channels are sampled before the edge updates anything, so a beat
  // accepted at this edge is noted before its result can come back.
  always @(posedge clk) begin
    if (!rst) begin
      if (op_ch.valid && op_ch.ready)
        sb.note_op(op_ch.opcode, op_ch.push_value);
      if (res_ch.valid && res_ch.ready)
        sb.check_result({res_ch.popped_value, res_ch.popped_valid, res_ch.evicted_value,
                         res_ch.evicted, res_ch.fill_count});
    end
  end

  // Result side: ready drops in bursts while stalls are enabled.
  initial begin
    int stall_left;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        if (out_stalls_on && $urandom_range(0, 11) == 0)
          stall_left = $urandom_range(1, 19);
      end
    end
  end

  task automatic send_op(input logic [ors_pkg::OPCODE_WIDTH-1:0] op,
                         input logic [VALUE_WIDTH-1:0] value);
    if (in_gaps_on && $urandom_range(0, 9) == 0) begin
      op_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    op_ch.valid <= 1'b1;
    op_ch.opcode <= op;
    op_ch.push_value <= value;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
    ops_sent++;
  endtask

  task automatic run_segment(input seg_kind_t kind, input int len);
    int push_pct;
    int roll;
    logic [ors_pkg::OPCODE_WIDTH-1:0] op;
    case (kind)
      SEG_FILL:  push_pct = 100;
      SEG_GROW:  push_pct = 90;
      SEG_DRAIN: push_pct = 15;
      default:   push_pct = 50;
    endcase
    for (int i = 0; i < len; i++) begin
      if (ops_sent >= TARGET_OPS)
        break;
      if (ops_sent >= QUIET_OPS) begin
        in_gaps_on = 1'b0;
        out_stalls_on = 1'b0;
      end
      roll = $urandom_range(0, 999);
      if (kind != SEG_FILL && roll < 4)
        op = ors_pkg::OP_CLEAR;
      else if (kind != SEG_FILL && roll < 30)
        op = OP_UNUSED;
      else
        op = ($urandom_range(1, 100) <= push_pct) ? ors_pkg::OP_PUSH : ors_pkg::OP_POP;
      send_op(op, $urandom());
    end
  endtask

  initial begin
    int len;
    seg_kind_t kind;
    rst = 1'b1;
    op_ch.valid = 1'b0;
    op_ch.opcode = ors_pkg::OP_PUSH;
    op_ch.push_value = '0;
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    ops_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: value extremes, every opcode, popping an empty stack,
    // and clearing a stack that still holds entries.
    send_op(ors_pkg::OP_PUSH, 32'h0000_0000);
    send_op(ors_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_op(ors_pkg::OP_PUSH, 32'hAAAA_AAAA);
    send_op(ors_pkg::OP_PUSH, 32'h5555_5555);
    send_op(ors_pkg::OP_POP, 32'hFFFF_FFFF);
    send_op(OP_UNUSED, 32'hFFFF_FFFF);
    send_op(ors_pkg::OP_POP, '0);
    send_op(ors_pkg::OP_POP, '0);
    send_op(ors_pkg::OP_POP, '0);
    send_op(ors_pkg::OP_POP, '0);
    send_op(OP_UNUSED, '0);
    send_op(ors_pkg::OP_PUSH, 32'h1234_5678);
    send_op(ors_pkg::OP_PUSH, 32'h8000_0001);
    send_op(ors_pkg::OP_CLEAR, 32'hFFFF_FFFF);
    send_op(ors_pkg::OP_POP, '0);
    send_op(ors_pkg::OP_PUSH, 32'h0000_0001);
    send_op(ors_pkg::OP_POP, '0);
    send_op(ors_pkg::OP_POP, '0);

    // Fill past capacity so the oldest entries get evicted, then drain.
    run_segment(SEG_FILL, CAPACITY + $urandom_range(4, 40));
    run_segment(SEG_DRAIN, $urandom_range(60, 200));

    while (ops_sent < TARGET_OPS) begin
      if (ops_sent < QUIET_OPS) begin
        in_gaps_on = ($urandom_range(0, 3) != 0);
        out_stalls_on = ($urandom_range(0, 3) != 0);
      end
      kind = seg_kind_t'($urandom_range(0, 3));
      len = (kind == SEG_FILL || kind == SEG_GROW) ? $urandom_range(40, 320)
                                                   : $urandom_range(10, 120);
      run_segment(kind, len);
    end

    op_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
